// ===== design/brf_pkg.sv =====
// brf_pkg: shared constants, types and helpers for the byte ring fifo
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int MAX_BURST   = 64;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int BYTE_W      = 8;
	localparam int ACT_W       = 2;
	localparam int REQ_W       = 7;
	localparam int CNT_W       = 10;
	localparam int BURST_W     = $clog2(MAX_BURST + 1);
	localparam int WIDE_W      = (IDX_W > REQ_W) ? IDX_W + 1 : REQ_W + 1;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [BURST_W-1:0] burst_t;
	typedef logic [BYTE_W-1:0]  byte_t;

	// memory port requests from the controller
	typedef struct packed {
		logic  we;
		idx_t  waddr;
		byte_t wdata;
		logic  re;
		idx_t  raddr;
	} mem_ctl_t;

	// result stage flags, aligned with the memory read data
	typedef struct packed {
		logic strobe;
		logic byte_valid;
		logic last;
		logic accepted;
	} rslt_t;

	// ring increment with wrap at the store depth
	function automatic idx_t next_idx(input idx_t idx);
		idx_t res;
		if (idx == idx_t'(STORE_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = idx + idx_t'(1);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== design/byte_ring_fifo.sv =====
// byte_ring_fifo: top level of the circular byte fifo with peek
//
// Command channel: an item (action, byte_in, count) is taken at a rising
// edge with start high and busy low. Actions: write one byte, read and
// remove up to count bytes, peek up to count bytes, clear.
// Result channel: each result is shown for one cycle with strobe high and
// cannot be held off. Every result carries the used and free counts after
// the whole item; last marks the final result of an item.
// Latency: a write, a clear, or a read/peek that grants no bytes gives its
// single result one cycle after acceptance, and a new item may be taken
// every cycle. A read or peek of n bytes (n up to 64) enters the burst
// state, and its bytes are read from the store, registered and shown at
// one byte per cycle, as the single read port of the byte store is walked
// once per byte; busy is high during the burst, so no item is taken then.
// Reset empties the ring at once; the byte store needs no clearing pass.
// The receiver cannot stall the block.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo
	import brf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic [REQ_W-1:0]  count,
	output      logic              strobe,
	output      logic [BYTE_W-1:0] byte_out,
	output      logic              byte_valid,
	output      logic              last,
	output      logic              accepted,
	output      logic [CNT_W-1:0]  used_count,
	output      logic [CNT_W-1:0]  free_count
);

	mem_ctl_t mem_ctl;
	rslt_t    rslt_s1;
	idx_t     used_q;
	byte_t    rdata;

	// pointers and sequencing
	brf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.action  (action),
		.byte_in (byte_in),
		.count   (count),
		.busy    (busy),
		.mem_ctl (mem_ctl),
		.rslt_s1 (rslt_s1),
		.used_q  (used_q)
	);

	// byte store
	brf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_ctl.we),
		.waddr (mem_ctl.waddr),
		.wdata (mem_ctl.wdata),
		.re    (mem_ctl.re),
		.raddr (mem_ctl.raddr),
		.rdata (rdata)
	);

	// result fields
	assign strobe     = rslt_s1.strobe;
	assign byte_valid = rslt_s1.byte_valid;
	assign last       = rslt_s1.last;
	assign accepted   = rslt_s1.accepted;
	assign byte_out   = rslt_s1.byte_valid ? rdata : '0;
	assign used_count = CNT_W'(used_q);
	assign free_count = CNT_W'(idx_t'(STORE_DEPTH - 1) - used_q);

endmodule

`default_nettype wire

// ===== design/brf_ram.sv =====
// brf_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/brf_ctrl.sv =====
// brf_ctrl: ring pointers, fill level and burst read sequencer
`timescale 1ns / 1ps
`default_nettype none

module brf_ctrl
	import brf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ACT_W-1:0]  action,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic [REQ_W-1:0]  count,
	output      logic              busy,
	output      mem_ctl_t          mem_ctl,
	output      rslt_t             rslt_s1,
	output      idx_t              used_q
);

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} state_t;

	state_t  state_q;
	idx_t    front_q;
	idx_t    rear_q;
	idx_t    rd_ptr_q;
	burst_t  rem_q;

	logic                accept;
	action_t             act;
	logic                full;
	logic [WIDE_W-1:0]   want_w;
	logic [WIDE_W-1:0]   used_w;
	logic [WIDE_W-1:0]   n_w;
	burst_t              n_bytes;
	logic [IDX_W:0]      front_sum;
	idx_t                front_adv;

	assign busy   = (state_q == ST_BURST);
	assign accept = start && !busy;
	assign act    = action_t'(action);
	assign full   = (used_q == idx_t'(STORE_DEPTH - 1));

	// bytes granted: request saturated to the burst limit, then to the fill level
	always_comb begin
		want_w = WIDE_W'(count);
		if (want_w > WIDE_W'(MAX_BURST)) begin
			want_w = WIDE_W'(MAX_BURST);
		end
		used_w = WIDE_W'(used_q);
		n_w    = (used_w < want_w) ? used_w : want_w;
	end
	assign n_bytes = BURST_W'(n_w);

	// front pointer after removing the granted bytes
	always_comb begin
		front_sum = {1'b0, front_q} + (IDX_W + 1)'(n_bytes);
		if (front_sum >= (IDX_W + 1)'(STORE_DEPTH)) begin
			front_sum = front_sum - (IDX_W + 1)'(STORE_DEPTH);
		end
		front_adv = front_sum[IDX_W-1:0];
	end

	// memory requests
	always_comb begin
		mem_ctl.we    = accept && (act == ACT_WRITE) && !full;
		mem_ctl.waddr = rear_q;
		mem_ctl.wdata = byte_in;
		mem_ctl.re    = (state_q == ST_BURST);
		mem_ctl.raddr = rd_ptr_q;
	end

	// sequencer state and registered result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			front_q  <= '0;
			rear_q   <= '0;
			used_q   <= '0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
			rslt_s1  <= '0;
		end else begin
			rslt_s1 <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (act)
							ACT_WRITE: begin
								rslt_s1.strobe   <= 1'b1;
								rslt_s1.last     <= 1'b1;
								rslt_s1.accepted <= !full;
								if (!full) begin
									rear_q <= next_idx(rear_q);
									used_q <= used_q + idx_t'(1);
								end
							end
							ACT_CLEAR: begin
								rslt_s1.strobe <= 1'b1;
								rslt_s1.last   <= 1'b1;
								front_q        <= '0;
								rear_q         <= '0;
								used_q         <= '0;
							end
							ACT_READ, ACT_PEEK: begin
								if (n_bytes == '0) begin
									rslt_s1.strobe <= 1'b1;
									rslt_s1.last   <= 1'b1;
								end else begin
									state_q  <= ST_BURST;
									rd_ptr_q <= front_q;
									rem_q    <= n_bytes;
									if (act == ACT_READ) begin
										front_q <= front_adv;
										used_q  <= used_q - idx_t'(n_bytes);
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_BURST: begin
					// one read issued per cycle, flags line up with the read data
					rslt_s1.strobe     <= 1'b1;
					rslt_s1.byte_valid <= 1'b1;
					rslt_s1.last       <= (rem_q == burst_t'(1));
					rd_ptr_q           <= next_idx(rd_ptr_q);
					rem_q              <= rem_q - burst_t'(1);
					if (rem_q == burst_t'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/brf_checker.sv =====
// brf_checker: port level assertions for the byte ring fifo, bound to the top
`timescale 1ns / 1ps
`default_nettype none

module brf_checker
	import brf_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              strobe,
	input wire logic [BYTE_W-1:0] byte_out,
	input wire logic              byte_valid,
	input wire logic              last,
	input wire logic              accepted,
	input wire logic [CNT_W-1:0]  used_count,
	input wire logic [CNT_W-1:0]  free_count
);

	// an accepted item answers next cycle or starts a burst
	a_item_answered: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> strobe || busy)
		else $error("accepted item gave neither a result nor a burst");

	// a burst streams without gaps until its last byte
	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && byte_valid)
		else $error("gap inside a read burst");

	// used and free add up to the ring capacity whenever a result is shown
	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ({1'b0, used_count} + {1'b0, free_count}) ==
			(CNT_W + 1)'(STORE_DEPTH - 1))
		else $error("used and free counts disagree");

	// a result without a byte is a single final result with a zero byte
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !byte_valid |-> last && (byte_out == '0))
		else $error("empty result malformed");

	// an accepted write never carries a byte
	a_write_flag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && accepted |-> !byte_valid && last)
		else $error("accepted flag on a byte result");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.byte_out   (byte_out),
	.byte_valid (byte_valid),
	.last       (last),
	.accepted   (accepted),
	.used_count (used_count),
	.free_count (free_count)
);

`default_nettype wire
